// ===== rtl/srsw_pkg.sv =====
// Shared types and constants of the selective-repeat sender window.
package srsw_pkg;

  localparam int SEQ_SPACE = 8;
  localparam int WINDOW    = 4;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int SN_W      = 8;

  // The outstanding count cannot reach SEQ_SPACE, so the usable window stops one short.
  localparam int EFF_WINDOW_INT = (WINDOW < SEQ_SPACE) ? WINDOW : (SEQ_SPACE - 1);
  localparam logic [SEQ_W-1:0] EFF_WINDOW = SEQ_W'(EFF_WINDOW_INT);

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [SN_W-1:0] seq_number;
    logic            checksum_ok;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic [SEQ_W-1:0] assigned_seq;
    logic [SEQ_W-1:0] resend_seq;
    logic             resend_valid;
    logic             timer_start;
    logic             timer_stop;
    logic [SEQ_W-1:0] timer_seq;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] next_seq;
    logic             window_full;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the window state and register the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

// ===== rtl/srsw_ctrl.sv =====
// Controller state machine of the selective-repeat sender window.
module srsw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output srsw_pkg::cmd_t    cmd,
  input  srsw_pkg::status_t status
);
  import srsw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/srsw_dp.sv =====
// Datapath of the selective-repeat sender window: window state, ack bitmap, result register.
module srsw_dp (
  input  logic              clk,
  input  logic              rst,
  input  srsw_pkg::req_t    req,
  input  srsw_pkg::cmd_t    cmd,
  output srsw_pkg::status_t status,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output srsw_pkg::rsp_t    rsp
);
  import srsw_pkg::*;

  logic [SEQ_SPACE-1:0] acked;
  logic [SEQ_W-1:0]     base;
  logic [SEQ_W-1:0]     nxt;
  req_t                 req_q;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;

  logic [SEQ_SPACE-1:0] acked_next;
  logic [SEQ_W-1:0]     base_next;
  logic [SEQ_W-1:0]     nxt_next;
  rsp_t                 res;

  always_comb begin
    logic [SEQ_W-1:0] sn_lo;
    logic             sn_ok;
    logic [SEQ_W-1:0] len;
    logic [SEQ_W-1:0] j;
    logic             stop;
    logic             full_cur;

    sn_lo      = req_q.seq_number[SEQ_W-1:0];
    sn_ok      = ({1'b0, req_q.seq_number} < (SN_W+1)'(SEQ_SPACE));
    full_cur   = ((nxt - base) >= EFF_WINDOW);
    len        = nxt - base;
    j          = base;
    stop       = 1'b0;
    acked_next = acked;
    base_next  = base;
    nxt_next   = nxt;
    res        = '0;

    case (opcode_t'(req_q.opcode))
      OP_SEND: begin
        if (!full_cur) begin
          acked_next[nxt]  = 1'b0;
          res.accepted     = 1'b1;
          res.assigned_seq = nxt;
          res.timer_start  = 1'b1;
          res.timer_seq    = nxt;
          nxt_next         = nxt + 1'b1;
        end
      end
      OP_ACK: begin
        if (sn_ok && req_q.checksum_ok && !acked[sn_lo] && ((sn_lo - base) < EFF_WINDOW)) begin
          acked_next[sn_lo] = 1'b1;
          res.accepted      = 1'b1;
          res.timer_stop    = 1'b1;
          res.timer_seq     = sn_lo;
          if (sn_lo == base) begin
            // Slide the base past the run of acknowledged numbers that follows it.
            base_next        = nxt;
            acked_next[base] = 1'b0;
            for (int k = 1; k < SEQ_SPACE; k++) begin
              j = base + SEQ_W'(k);
              if (!stop && (SEQ_W'(k) < len)) begin
                if (!acked_next[j]) begin
                  base_next = j;
                  stop      = 1'b1;
                end else begin
                  acked_next[j] = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (sn_ok) begin
          res.resend_valid = 1'b1;
          res.resend_seq   = sn_lo;
          res.timer_start  = 1'b1;
          res.timer_seq    = sn_lo;
        end
      end
      default: begin
      end
    endcase

    res.window_base = base_next;
    res.next_seq    = nxt_next;
    res.window_full = ((nxt_next - base_next) >= EFF_WINDOW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked       <= '0;
      base        <= '0;
      nxt         <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd.exec) begin
        acked       <= acked_next;
        base        <= base_next;
        nxt         <= nxt_next;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      rsp_q <= res;
    end
  end

  assign status.out_free = !rsp_valid_q || rsp_ready;
  assign rsp_valid       = rsp_valid_q;
  assign rsp             = rsp_q;

endmodule

// ===== rtl/selective_repeat_sender_window.sv =====
// An accepted transaction is captured, then executed against the window state with its result
// registered. No new transaction is taken until it has executed, as set by the capture and execute
// states of the controller; execution waits while a previous result has not yet been taken.
// Reset (rst, synchronous, active high) clears the ack bitmap, window base, next sequence
// number and the result valid flag; the block is ready for a transaction right after reset.
module selective_repeat_sender_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  srsw_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output srsw_pkg::rsp_t  rsp
);
  import srsw_pkg::*;

  // The controller sequences each transaction: capture it, then execute it against the
  // window state once the result register is free.
  cmd_t    cmd;
  status_t status;

  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the window base, next number and ack bitmap. An ack for the base
  // slides it across the acknowledged run in the same execute cycle, and the result sits
  // in its own register so a new transaction can be captured while it waits.
  srsw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== bench/selective_repeat_sender_window_tb.sv =====
// Self-checking testbench for the selective-repeat sender window controller.
`timescale 1ns / 1ps

module selective_repeat_sender_window_tb;
  import srsw_pkg::*;

  // Cycles without any accepted transaction on either channel before the run is abandoned.
  // The longest idle gap of the sender and the longest receiver stall are both far below it.
  localparam int QUIET_LIMIT = 5000;

  // Enough cycles after the last result for a stray extra result to show up.
  localparam int TAIL_CYCLES = 12;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  selective_repeat_sender_window u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // The testbench's own copy of the window state. It is updated at the clock edge where a
  // request transaction is accepted, so the stimulus can read it to aim acks and timeouts.
  bit acked_map [SEQ_SPACE];
  int win_base;
  int win_next;

  // Results the block still owes, oldest first.
  rsp_t pending_rsp_q [$];

  int mismatch_count;
  int quiet_cycles;
  int rsp_checked;
  int sends_taken;
  int sends_refused;
  int acks_taken;
  int acks_ignored;
  int resends;
  int base_acks;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Distance from one sequence number forward to another, modulo the sequence space.
  function automatic int seq_dist(input int from, input int to);
    return (to + SEQ_SPACE - from) % SEQ_SPACE;
  endfunction

  function automatic bit window_is_full();
    return seq_dist(win_base, win_next) >= EFF_WINDOW_INT;
  endfunction

  // Applies one request to the window state and returns the result the block must produce.
  function automatic rsp_t predict_window(input req_t r);
    rsp_t o;
    int   sn;
    int   span;
    int   j;
    int   new_base;
    int   i;
    bit   found;
    o  = '0;
    sn = int'(r.seq_number);
    case (opcode_t'(r.opcode))
      OP_SEND: begin
        if (!window_is_full()) begin
          acked_map[win_next] = 1'b0;
          o.accepted     = 1'b1;
          o.assigned_seq = SEQ_W'(win_next);
          o.timer_start  = 1'b1;
          o.timer_seq    = SEQ_W'(win_next);
          win_next       = (win_next + 1) % SEQ_SPACE;
          sends_taken++;
        end else begin
          sends_refused++;
        end
      end
      OP_ACK: begin
        // Taken only when the number is in range, the checksum matched, the bit is still
        // clear and the number falls inside the window starting at the base.
        if (sn < SEQ_SPACE && r.checksum_ok && !acked_map[sn] &&
            seq_dist(win_base, sn) < EFF_WINDOW_INT) begin
          acked_map[sn] = 1'b1;
          o.accepted    = 1'b1;
          o.timer_stop  = 1'b1;
          o.timer_seq   = SEQ_W'(sn);
          acks_taken++;
          if (sn == win_base) begin
            // Slide past every consecutive acknowledged entry, clearing the bits passed.
            // With everything outstanding acknowledged the base catches up with next_seq.
            span     = seq_dist(win_base, win_next);
            new_base = win_next;
            found    = 1'b0;
            j        = win_base;
            acked_map[j] = 1'b0;
            for (i = 1; i < span && !found; i++) begin
              j = (j + 1) % SEQ_SPACE;
              if (!acked_map[j]) begin
                new_base = j;
                found    = 1'b1;
              end else begin
                acked_map[j] = 1'b0;
              end
            end
            win_base = new_base;
            base_acks++;
          end
        end else begin
          acks_ignored++;
        end
      end
      OP_TIMEOUT: begin
        // Any number inside the sequence space is resent, outstanding or not.
        if (sn < SEQ_SPACE) begin
          o.resend_valid = 1'b1;
          o.resend_seq   = SEQ_W'(sn);
          o.timer_start  = 1'b1;
          o.timer_seq    = SEQ_W'(sn);
          resends++;
        end
      end
      default: begin
      end
    endcase
    o.window_base = SEQ_W'(win_base);
    o.next_seq    = SEQ_W'(win_next);
    o.window_full = window_is_full();
    return o;
  endfunction

  function automatic req_t make_req(input opcode_t op, input int sn, input bit ck);
    req_t r;
    r.opcode      = op;
    r.seq_number  = SN_W'(sn);
    r.checksum_ok = ck;
    return r;
  endfunction

  // Offers one request transaction and holds it until the block accepts it. Valid is left
  // high so that the next call can follow back to back without a bubble.
  task automatic send_request(input req_t item);
    @(negedge clk);
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_rsp_q.push_back(predict_window(item));
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    req_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops offering requests until every expected result has been taken.
  task automatic drain_results();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Right after reset: a no-op only reports status, an out-of-range timeout is ignored, and an
  // ack of the base while nothing is outstanding is still inside the window and gets taken.
  task automatic test_idle_status();
    send_request(make_req(OP_NOP, 255, 1'b1));
    send_request(make_req(OP_TIMEOUT, 255, 1'b1));
    send_request(make_req(OP_ACK, 0, 1'b1));
  endtask

  // Four sends fill the window; the fifth is refused and changes nothing.
  task automatic test_fill_window();
    repeat (EFF_WINDOW_INT + 1) send_request(make_req(OP_SEND, 0, 1'b0));
  endtask

  // Bad checksum, out-of-range number, number past the window and a duplicate are all
  // ignored. Acks out of order hold the base until the base itself is acknowledged.
  task automatic test_ack_rules();
    send_request(make_req(OP_ACK, 1, 1'b0));
    send_request(make_req(OP_ACK, SEQ_SPACE, 1'b1));
    send_request(make_req(OP_ACK, 4, 1'b1));
    send_request(make_req(OP_ACK, 2, 1'b1));
    send_request(make_req(OP_ACK, 2, 1'b1));
    send_request(make_req(OP_ACK, 1, 1'b1));
    send_request(make_req(OP_ACK, 0, 1'b1));
  endtask

  // An ack for a number not yet sent but inside the window marks its bit; sending that
  // number later clears it again, so the base slide cannot count it as acknowledged.
  task automatic test_ack_ahead_of_send();
    send_request(make_req(OP_ACK, 5, 1'b1));
    send_request(make_req(OP_SEND, 0, 1'b1));
    send_request(make_req(OP_SEND, 0, 1'b1));
    send_request(make_req(OP_ACK, 3, 1'b1));
  endtask

  // Timeouts resend any number in the space, even one not outstanding.
  task automatic test_timeouts();
    send_request(make_req(OP_TIMEOUT, 0, 1'b0));
    send_request(make_req(OP_TIMEOUT, SEQ_SPACE - 1, 1'b1));
    send_request(make_req(OP_TIMEOUT, SEQ_SPACE, 1'b1));
  endtask

  // Fill the window across the wrap from the top sequence number to zero, then ack the base
  // last so that one ack slides the base all the way around to next_seq.
  task automatic test_wraparound();
    send_request(make_req(OP_SEND, 0, 1'b1));
    send_request(make_req(OP_SEND, 0, 1'b1));
    send_request(make_req(OP_ACK, 6, 1'b1));
    send_request(make_req(OP_ACK, 7, 1'b1));
    send_request(make_req(OP_ACK, 5, 1'b1));
    send_request(make_req(OP_ACK, 4, 1'b1));
  endtask

  // Mostly well-formed traffic: sends, acks aimed at outstanding numbers (sometimes just past
  // next_seq) and timeouts of outstanding numbers, mixed with random noise. Every request
  // counts toward the goal. Halfway through, the sender drains the block once.
  task automatic test_random_traffic(input int goal);
    int   sent;
    int   burst;
    int   pick;
    int   span;
    int   off;
    bit   drained;
    req_t item;
    sent    = 0;
    burst   = 0;
    drained = 1'b0;
    while (sent < goal) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 9));
      end
      burst--;
      if (!drained && sent >= goal / 2) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      span = seq_dist(win_base, win_next);
      if (pick < 30) begin
        item = make_req(OP_SEND, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else if (pick < 65) begin
        if (span > 0 && $urandom_range(0, 4) != 0) off = $urandom_range(0, span - 1);
        else off = $urandom_range(0, EFF_WINDOW_INT - 1);
        item = make_req(OP_ACK, (win_base + off) % SEQ_SPACE, $urandom_range(0, 9) != 0);
      end else if (pick < 78) begin
        if (span > 0) off = (win_base + $urandom_range(0, span - 1)) % SEQ_SPACE;
        else off = $urandom_range(0, SEQ_SPACE - 1);
        item = make_req(OP_TIMEOUT, off, 1'($urandom_range(0, 1)));
      end else begin
        item = make_req(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                        1'($urandom_range(0, 1)));
      end
      send_request(item);
      sent++;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // The receiver stalls on a pattern of its own: stretches of steady readiness, stretches of
  // light random stalls and stretches where ready is mostly low.
  initial begin : rsp_stall_pattern
    int stall_mode;
    int stretch;
    rsp_ready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 2);
      stretch    = $urandom_range(16, 80);
      repeat (stretch) begin
        @(negedge clk);
        case (stall_mode)
          0:       rsp_ready = 1'b1;
          1:       rsp_ready = $urandom_range(0, 3) != 0;
          default: rsp_ready = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // Every result transaction is compared against the oldest outstanding expectation.
  always @(posedge clk) begin : rsp_checker
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: result transaction with none expected: got %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        rsp_checked++;
        check_field("accepted", 8'(want.accepted), 8'(rsp.accepted));
        check_field("assigned_seq", 8'(want.assigned_seq), 8'(rsp.assigned_seq));
        check_field("resend_seq", 8'(want.resend_seq), 8'(rsp.resend_seq));
        check_field("resend_valid", 8'(want.resend_valid), 8'(rsp.resend_valid));
        check_field("timer_start", 8'(want.timer_start), 8'(rsp.timer_start));
        check_field("timer_stop", 8'(want.timer_stop), 8'(rsp.timer_stop));
        check_field("timer_seq", 8'(want.timer_seq), 8'(rsp.timer_seq));
        check_field("window_base", 8'(want.window_base), 8'(rsp.window_base));
        check_field("next_seq", 8'(want.next_seq), 8'(rsp.next_seq));
        check_field("window_full", 8'(want.window_full), 8'(rsp.window_full));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // A hung handshake ends the run as a failure.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles, %0d results still expected",
             $time, QUIET_LIMIT, pending_rsp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run_tests
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    win_base  = 0;
    win_next  = 0;
    foreach (acked_map[k]) acked_map[k] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_status();
    test_fill_window();
    test_ack_rules();
    test_ack_ahead_of_send();
    test_timeouts();
    test_wraparound();
    test_random_traffic(420);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d sends taken and %0d refused at a full window,",
             sends_taken, sends_refused);
    $display("%0d acks taken, %0d ignored, %0d resend requests, %0d acks of the base; %0d compared.",
             acks_taken, acks_ignored, resends, base_acks, rsp_checked);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
